@@ src/sip_pkg.sv @@
// ----------------------------------------------------------------------------
// sip_pkg
// Shared widths, types and status codes of the segment intersection core.
// ----------------------------------------------------------------------------
package sip_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int OUT_W      = 32;

  localparam int DW   = COORD_BITS + 1;
  localparam int PW   = 2 * DW;
  localparam int XW   = PW + 1;
  localparam int TL   = XW / 2;
  localparam int PRW  = DW + XW;
  localparam int NW   = PRW + FRAC_BITS + 2;
  localparam int QB   = ((COORD_BITS - 1 + FRAC_BITS) > OUT_W ?
                         (COORD_BITS - 1 + FRAC_BITS) : OUT_W) + 2;
  localparam int RW   = NW + QB;
  localparam int VW   = QB + 2;

  localparam int FRONT_LAT = 4;
  localparam int LANE_LAT  = QB + 5;
  localparam int DEPTH     = FRONT_LAT + LANE_LAT;

  localparam int ADDR_W = 1;
  localparam logic [ADDR_W-1:0] REG_MODE = '0;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DW-1:0]         diff_t;
  typedef logic signed [PW-1:0]         prod_t;
  typedef logic signed [XW-1:0]         cross_t;

  typedef enum logic [2:0] {
    ST_FOUND    = 3'd0,
    ST_ZERO_LEN = 3'd1,
    ST_SHARED   = 3'd2,
    ST_NO_CROSS = 3'd3,
    ST_OUTSIDE  = 3'd4,
    ST_PARALLEL = 3'd5
  } status_e;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
    coord_t cx;
    coord_t cy;
    coord_t dx;
    coord_t dy;
  } pts_t;

  typedef struct packed {
    status_e          status;
    coord_t           base_x;
    coord_t           base_y;
    diff_t            step_x;
    diff_t            step_y;
    cross_t           tn;
    logic [XW-1:0]    den;
  } front_t;

endpackage

@@ src/sip_if.sv @@
// ----------------------------------------------------------------------------
// sip_if
// Valid/ready channels carrying the point sets and the intersection results.
// ----------------------------------------------------------------------------
interface sip_in_if;
  import sip_pkg::*;
  logic   valid;
  logic   ready;
  coord_t ax;
  coord_t ay;
  coord_t bx;
  coord_t by;
  coord_t cx;
  coord_t cy;
  coord_t dx;
  coord_t dy;
  modport source (output valid, ax, ay, bx, by, cx, cy, dx, dy, input ready);
  modport sink   (input valid, ax, ay, bx, by, cx, cy, dx, dy, output ready);
endinterface

interface sip_out_if;
  import sip_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [2:0]              status;
  logic signed [OUT_W-1:0] point_x;
  logic signed [OUT_W-1:0] point_y;
  modport source (output valid, status, point_x, point_y, input ready);
  modport sink   (input valid, status, point_x, point_y, output ready);
endinterface

@@ src/sip_front.sv @@
// ----------------------------------------------------------------------------
// sip_front
// Four-stage geometry front end: differences, products, cross products,
// then status decision and sign normalisation of the crossing parameter.
// ----------------------------------------------------------------------------
module sip_front import sip_pkg::*; (
  input  logic   clk_i,
  input  logic   en_i,
  input  logic   mode_i,
  input  pts_t   pts_i,
  output front_t res_o
);

  // stage 1
  coord_t s1_ax_q, s1_ay_q;
  diff_t  s1_vbx_q, s1_vby_q, s1_vcx_q, s1_vcy_q, s1_vdx_q, s1_vdy_q, s1_ex_q, s1_ey_q;
  logic   s1_zl_q, s1_sh_q, s1_mode_q;
  logic   zl_d, sh_d;

  // stage 2
  coord_t s2_ax_q, s2_ay_q;
  diff_t  s2_vbx_q, s2_vby_q;
  prod_t  s2_p_q [8];
  logic   s2_zl_q, s2_sh_q, s2_mode_q;

  // stage 3
  coord_t s3_ax_q, s3_ay_q;
  diff_t  s3_vbx_q, s3_vby_q;
  cross_t s3_sc_q, s3_sd_q, s3_den_q, s3_tn_q;
  logic   s3_zl_q, s3_sh_q, s3_mode_q;

  // stage 4
  front_t s4_q;
  front_t s4_d;
  logic [XW-1:0] dn;
  cross_t        tnn;

  always_comb begin
    zl_d = (pts_i.ax == pts_i.bx && pts_i.ay == pts_i.by) ||
           (pts_i.cx == pts_i.dx && pts_i.cy == pts_i.dy);
    sh_d = (pts_i.ax == pts_i.cx && pts_i.ay == pts_i.cy) ||
           (pts_i.bx == pts_i.cx && pts_i.by == pts_i.cy) ||
           (pts_i.ax == pts_i.dx && pts_i.ay == pts_i.dy) ||
           (pts_i.bx == pts_i.dx && pts_i.by == pts_i.dy);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_ax_q   <= pts_i.ax;
      s1_ay_q   <= pts_i.ay;
      s1_vbx_q  <= DW'(pts_i.bx) - DW'(pts_i.ax);
      s1_vby_q  <= DW'(pts_i.by) - DW'(pts_i.ay);
      s1_vcx_q  <= DW'(pts_i.cx) - DW'(pts_i.ax);
      s1_vcy_q  <= DW'(pts_i.cy) - DW'(pts_i.ay);
      s1_vdx_q  <= DW'(pts_i.dx) - DW'(pts_i.ax);
      s1_vdy_q  <= DW'(pts_i.dy) - DW'(pts_i.ay);
      s1_ex_q   <= DW'(pts_i.dx) - DW'(pts_i.cx);
      s1_ey_q   <= DW'(pts_i.dy) - DW'(pts_i.cy);
      s1_zl_q   <= zl_d;
      s1_sh_q   <= sh_d;
      s1_mode_q <= mode_i;

      s2_ax_q   <= s1_ax_q;
      s2_ay_q   <= s1_ay_q;
      s2_vbx_q  <= s1_vbx_q;
      s2_vby_q  <= s1_vby_q;
      s2_p_q[0] <= PW'(s1_vbx_q) * PW'(s1_vcy_q);
      s2_p_q[1] <= PW'(s1_vby_q) * PW'(s1_vcx_q);
      s2_p_q[2] <= PW'(s1_vbx_q) * PW'(s1_vdy_q);
      s2_p_q[3] <= PW'(s1_vby_q) * PW'(s1_vdx_q);
      s2_p_q[4] <= PW'(s1_vbx_q) * PW'(s1_ey_q);
      s2_p_q[5] <= PW'(s1_vby_q) * PW'(s1_ex_q);
      s2_p_q[6] <= PW'(s1_vcx_q) * PW'(s1_ey_q);
      s2_p_q[7] <= PW'(s1_vcy_q) * PW'(s1_ex_q);
      s2_zl_q   <= s1_zl_q;
      s2_sh_q   <= s1_sh_q;
      s2_mode_q <= s1_mode_q;

      s3_ax_q   <= s2_ax_q;
      s3_ay_q   <= s2_ay_q;
      s3_vbx_q  <= s2_vbx_q;
      s3_vby_q  <= s2_vby_q;
      s3_sc_q   <= XW'(s2_p_q[0]) - XW'(s2_p_q[1]);
      s3_sd_q   <= XW'(s2_p_q[2]) - XW'(s2_p_q[3]);
      s3_den_q  <= XW'(s2_p_q[4]) - XW'(s2_p_q[5]);
      s3_tn_q   <= XW'(s2_p_q[6]) - XW'(s2_p_q[7]);
      s3_zl_q   <= s2_zl_q;
      s3_sh_q   <= s2_sh_q;
      s3_mode_q <= s2_mode_q;

      s4_q      <= s4_d;
    end
  end

  always_comb begin
    dn  = s3_den_q[XW-1] ? XW'(-s3_den_q) : XW'(s3_den_q);
    tnn = s3_den_q[XW-1] ? -s3_tn_q : s3_tn_q;
    s4_d.status = ST_FOUND;
    if (s3_zl_q) begin
      s4_d.status = ST_ZERO_LEN;
    end else if (!s3_mode_q && s3_sh_q) begin
      s4_d.status = ST_SHARED;
    end else if (!s3_mode_q && (s3_sc_q[XW-1] == s3_sd_q[XW-1])) begin
      s4_d.status = ST_NO_CROSS;
    end else if (s3_mode_q && s3_den_q == '0) begin
      s4_d.status = ST_PARALLEL;
    end else if (!s3_mode_q &&
                 (tnn[XW-1] || ((XW+1)'(tnn) > $signed({1'b0, dn})))) begin
      s4_d.status = ST_OUTSIDE;
    end
    s4_d.base_x = s3_ax_q;
    s4_d.base_y = s3_ay_q;
    s4_d.step_x = s3_vbx_q;
    s4_d.step_y = s3_vby_q;
    s4_d.tn     = tnn;
    s4_d.den    = dn;
  end

  assign res_o = s4_q;

endmodule

@@ src/sip_lane.sv @@
// ----------------------------------------------------------------------------
// sip_lane
// One coordinate: split product, rounding numerator, pipelined restoring
// divider one quotient bit per stage, then offset and saturate.
// ----------------------------------------------------------------------------
module sip_lane import sip_pkg::*; (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  coord_t                  base_i,
  input  diff_t                   step_i,
  input  cross_t                  tn_i,
  input  logic [XW-1:0]           den_i,
  output logic signed [OUT_W-1:0] value_o
);

  localparam logic signed [VW-1:0] VMAX = VW'({1'b0, {(OUT_W-1){1'b1}}});
  localparam logic signed [VW-1:0] VMIN = -VMAX - VW'(1);

  // partial products
  logic signed [DW+TL:0]       pl_q;
  logic signed [DW+XW-TL-1:0]  ph_q;
  coord_t                      b5_q, b6_q, b7_q, b8_q;
  logic [XW-1:0]               dn5_q, dn6_q;
  logic signed [PRW-1:0]       p_q;
  logic [PRW-1:0]              mag;
  logic [NW-1:0]               n_q;
  logic [XW:0]                 d7_q;
  logic                        neg7_q;
  logic [RW-1:0]               r8_q;
  logic [XW:0]                 d8_q;
  logic                        neg8_q, ovf8_q;

  logic [RW-1:0] r_q   [QB];
  logic [QB-1:0] qt_q  [QB];
  logic [XW:0]   dv_q  [QB];
  coord_t        bs_q  [QB];
  logic          ng_q  [QB];
  logic          ov_q  [QB];

  logic signed [VW-1:0]    off, vsum;
  logic signed [OUT_W-1:0] value_d, value_q;

  assign mag = p_q[PRW-1] ? PRW'(-p_q) : PRW'(p_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pl_q   <= step_i * $signed({1'b0, tn_i[TL-1:0]});
      ph_q   <= step_i * $signed(tn_i[XW-1:TL]);
      b5_q   <= base_i;
      dn5_q  <= den_i;

      p_q    <= (PRW'(ph_q) <<< TL) + PRW'(pl_q);
      b6_q   <= b5_q;
      dn6_q  <= dn5_q;

      n_q    <= (NW'(mag) << (FRAC_BITS + 1)) + NW'(dn6_q);
      d7_q   <= {dn6_q, 1'b0};
      neg7_q <= p_q[PRW-1];
      b7_q   <= b6_q;

      r8_q   <= RW'(n_q);
      ovf8_q <= RW'(n_q) >= (RW'(d7_q) << QB);
      d8_q   <= d7_q;
      neg8_q <= neg7_q;
      b8_q   <= b7_q;

      value_q <= value_d;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    localparam int BIT = QB - 1 - k;
    logic [RW-1:0] r_in, sh;
    logic [QB-1:0] qt_in, qt_d;
    logic [XW:0]   dv_in;
    coord_t        bs_in;
    logic          ng_in, ov_in, ge;

    if (k == 0) begin : g_first
      assign r_in  = r8_q;
      assign qt_in = '0;
      assign dv_in = d8_q;
      assign bs_in = b8_q;
      assign ng_in = neg8_q;
      assign ov_in = ovf8_q;
    end else begin : g_next
      assign r_in  = r_q[k-1];
      assign qt_in = qt_q[k-1];
      assign dv_in = dv_q[k-1];
      assign bs_in = bs_q[k-1];
      assign ng_in = ng_q[k-1];
      assign ov_in = ov_q[k-1];
    end

    always_comb begin
      sh        = RW'(dv_in) << BIT;
      ge        = r_in >= sh;
      qt_d      = qt_in;
      qt_d[BIT] = ge;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k]  <= ge ? r_in - sh : r_in;
        qt_q[k] <= qt_d;
        dv_q[k] <= dv_in;
        bs_q[k] <= bs_in;
        ng_q[k] <= ng_in;
        ov_q[k] <= ov_in;
      end
    end
  end

  always_comb begin
    off  = ng_q[QB-1] ? -VW'(qt_q[QB-1]) : VW'(qt_q[QB-1]);
    vsum = (VW'(bs_q[QB-1]) <<< FRAC_BITS) + off;
    if (ov_q[QB-1]) begin
      value_d = ng_q[QB-1] ? OUT_W'(VMIN) : OUT_W'(VMAX);
    end else if (vsum > VMAX) begin
      value_d = OUT_W'(VMAX);
    end else if (vsum < VMIN) begin
      value_d = OUT_W'(VMIN);
    end else begin
      value_d = vsum[OUT_W-1:0];
    end
  end

  assign value_o = value_q;

endmodule

@@ src/segment_intersection_point_core.sv @@
// ----------------------------------------------------------------------------
// segment_intersection_point_core
// Intersection of segment or line AB with CD, result in signed Q24.8.
//
//   channel  dir  handshake      payload
//   in_i     in   valid/ready    ax ay bx by cx cy dx dy (16b signed)
//   out_o    out  valid/ready    status (3b), point_x, point_y (32b signed)
//   apb      in   psel/penable   mode register at address 0
//
// One transaction per cycle sustained unless the output stalls; the pipe
// depth is set mostly by the one-bit-per-stage divider.
// The whole pipe advances when the output register is empty or taken.
// A stall holds every stage; nothing is dropped or repeated.
// Reset clears the valid line and mode.
// ----------------------------------------------------------------------------
module segment_intersection_point_core import sip_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  sip_in_if.sink            in_i,
  sip_out_if.source         out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic             mode_q;
  logic [DEPTH-1:0] vld_q;
  status_e          st_q [LANE_LAT];
  logic             en, in_acc, cfg_wr;
  pts_t             pts;
  front_t           fr;
  logic signed [OUT_W-1:0] lx, ly;

  assign pready = 1'b1;
  assign prdata = {31'b0, mode_q};
  assign cfg_wr = psel && penable && pwrite && (paddr == REG_MODE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_wr) begin
      mode_q <= pwdata[0];
    end
  end

  assign en       = !vld_q[DEPTH-1] || out_o.ready;
  assign in_i.ready = en;
  assign in_acc   = in_i.valid && en;

  assign pts = '{ax: in_i.ax, ay: in_i.ay, bx: in_i.bx, by: in_i.by,
                 cx: in_i.cx, cy: in_i.cy, dx: in_i.dx, dy: in_i.dy};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[DEPTH-2:0], in_acc};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q[0] <= fr.status;
      for (int i = 1; i < LANE_LAT; i++) begin
        st_q[i] <= st_q[i-1];
      end
    end
  end

  sip_front u_front (
    .clk_i  (clk_i),
    .en_i   (en),
    .mode_i (mode_q),
    .pts_i  (pts),
    .res_o  (fr)
  );

  sip_lane u_lane_x (
    .clk_i   (clk_i),
    .en_i    (en),
    .base_i  (fr.base_x),
    .step_i  (fr.step_x),
    .tn_i    (fr.tn),
    .den_i   (fr.den),
    .value_o (lx)
  );

  sip_lane u_lane_y (
    .clk_i   (clk_i),
    .en_i    (en),
    .base_i  (fr.base_y),
    .step_i  (fr.step_y),
    .tn_i    (fr.tn),
    .den_i   (fr.den),
    .value_o (ly)
  );

  assign out_o.valid   = vld_q[DEPTH-1];
  assign out_o.status  = st_q[LANE_LAT-1];
  assign out_o.point_x = (st_q[LANE_LAT-1] == ST_FOUND) ? lx : '0;
  assign out_o.point_y = (st_q[LANE_LAT-1] == ST_FOUND) ? ly : '0;

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("valid line moved during stall");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status != ST_FOUND |-> out_o.point_x == 0 && out_o.point_y == 0)
    else $error("failed result carries a point");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.status <= ST_PARALLEL)
    else $error("status code out of range");

  a_mode_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> mode_q == $past(pwdata[0]))
    else $error("mode write lost");

endmodule

@@ bench/sip_scoreboard.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sip_scoreboard
// Predicts the status and Q24.8 crossing point of each accepted point set
// and checks the results of the core against those predictions, in order.
// ----------------------------------------------------------------------------
class sip_scoreboard;
  typedef struct {
    sip_pkg::status_e    status;
    logic signed [31:0]  px;
    logic signed [31:0]  py;
  } crossing_t;

  crossing_t pending_q[$];
  bit        line_mode;
  int        n_errors;
  int        n_checked;
  int        n_status[6];

  function new();
    line_mode = 1'b0;
    n_errors  = 0;
    n_checked = 0;
  endfunction

  function void report(string what);
    n_errors++;
    $display("mismatch: %s", what);
  endfunction

  // base << FRAC + round(step * tn / den), den > 0, saturated
  function automatic logic signed [31:0] locate(longint base, longint step,
                                                 longint tn, longint den);
    longint   p;
    bit       neg;
    longint   mag;
    longint   q;
    longint   v;
    p   = step * tn;
    neg = p < 0;
    mag = neg ? -p : p;
    q   = ((mag << sip_pkg::FRAC_BITS) * 2 + den) / (2 * den);
    v   = base * (longint'(1) << sip_pkg::FRAC_BITS) + (neg ? -q : q);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function void note_points(sip_pkg::pts_t s);
    crossing_t r;
    longint ax, ay, bx, by, cx, cy, dx, dy;
    longint vbx, vby, vcx, vcy, vdx, vdy, ex, ey, sc, sd, den, tn;
    ax = s.ax; ay = s.ay; bx = s.bx; by = s.by;
    cx = s.cx; cy = s.cy; dx = s.dx; dy = s.dy;
    r.status = sip_pkg::ST_FOUND;
    r.px = '0;
    r.py = '0;
    vbx = bx - ax; vby = by - ay;
    vcx = cx - ax; vcy = cy - ay;
    vdx = dx - ax; vdy = dy - ay;
    ex  = dx - cx; ey  = dy - cy;
    sc  = vbx * vcy - vby * vcx;
    sd  = vbx * vdy - vby * vdx;
    den = vbx * ey - vby * ex;
    tn  = vcx * ey - vcy * ex;
    if ((ax == bx && ay == by) || (cx == dx && cy == dy)) begin
      r.status = sip_pkg::ST_ZERO_LEN;
    end else if (!line_mode && ((ax == cx && ay == cy) || (bx == cx && by == cy) ||
                               (ax == dx && ay == dy) || (bx == dx && by == dy))) begin
      r.status = sip_pkg::ST_SHARED;
    end else begin
      if (!line_mode) begin
        if ((sc < 0) == (sd < 0)) r.status = sip_pkg::ST_NO_CROSS;
      end else if (den == 0) begin
        r.status = sip_pkg::ST_PARALLEL;
      end
      if (r.status == sip_pkg::ST_FOUND) begin
        if (den < 0) begin
          den = -den;
          tn  = -tn;
        end
        if (!line_mode && (tn < 0 || tn > den)) r.status = sip_pkg::ST_OUTSIDE;
      end
      if (r.status == sip_pkg::ST_FOUND) begin
        r.px = locate(ax, vbx, tn, den);
        r.py = locate(ay, vby, tn, den);
      end
    end
    pending_q.push_back(r);
  endfunction

  function void check_crossing(logic [2:0] st, logic signed [31:0] px,
                               logic signed [31:0] py);
    crossing_t e;
    if (pending_q.size() == 0) begin
      report($sformatf("unexpected transaction status %0d", st));
      return;
    end
    e = pending_q.pop_front();
    n_checked++;
    n_status[e.status]++;
    if (st !== e.status)
      report($sformatf("status got %0d want %0d", st, e.status));
    if (px !== e.px)
      report($sformatf("point_x got %0d want %0d", px, e.px));
    if (py !== e.py)
      report($sformatf("point_y got %0d want %0d", py, e.py));
  endfunction
endclass

@@ bench/segment_intersection_point_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_intersection_point_core_test
// Drives point sets through the core in both modes under varied sender gaps
// and receiver stalls; every result is checked against a scoreboard.
// ----------------------------------------------------------------------------
module segment_intersection_point_core_test;
  import sip_pkg::*;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  int   send_idle_pct, recv_stall_pct;
  longint n_cycles;

  sip_in_if  pts_ch ();
  sip_out_if res_ch ();

  segment_intersection_point_core u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (pts_ch),
    .out_o   (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  sip_scoreboard sb = new();

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    n_cycles = 0;
    forever begin
      @(posedge clk_i);
      n_cycles++;
      if (n_cycles > 400000) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // receiver: random stalls, checks on handshake
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni) begin
        if (res_ch.valid && res_ch.ready)
          sb.check_crossing(res_ch.status, res_ch.point_x, res_ch.point_y);
        res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic write_mode(bit m);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_MODE;
    pwdata  <= {31'd0, m};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.line_mode = m;
  endtask

  task automatic drain();
    pts_ch.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (DEPTH + 5) @(posedge clk_i);
  endtask

  task automatic send_points(pts_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      pts_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    pts_ch.valid <= 1'b1;
    {pts_ch.ax, pts_ch.ay, pts_ch.bx, pts_ch.by,
     pts_ch.cx, pts_ch.cy, pts_ch.dx, pts_ch.dy} <= s;
    do @(posedge clk_i); while (!pts_ch.ready);
    sb.note_points(s);
  endtask

  function automatic coord_t rand_coord(int span);
    case ($urandom_range(5))
      0:       return coord_t'($urandom);
      1:       return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      default: return coord_t'(int'($urandom_range(2 * span)) - span);
    endcase
  endfunction

  // random segment pairs mostly, plus degenerate shapes
  function automatic pts_t rand_points();
    pts_t s;
    int   span;
    span = $urandom_range(3) == 0 ? 32767 : ($urandom_range(1) ? 40 : 2000);
    s = {rand_coord(span), rand_coord(span), rand_coord(span), rand_coord(span),
         rand_coord(span), rand_coord(span), rand_coord(span), rand_coord(span)};
    case ($urandom_range(9))
      0: {s.bx, s.by} = {s.ax, s.ay};
      1: {s.dx, s.dy} = {s.cx, s.cy};
      2: {s.cx, s.cy} = $urandom_range(1) ? {s.ax, s.ay} : {s.bx, s.by};
      3: begin
        s.dx = s.cx + (s.bx - s.ax);
        s.dy = s.cy + (s.by - s.ay);
      end
      4: begin
        s.cx = s.ax + (s.bx - s.ax) / 2;
        s.cy = s.ay + (s.by - s.ay) / 2;
      end
      default: ;
    endcase
    return s;
  endfunction

  task automatic run_phase(int n, int idle, int stall, bit m);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    drain();
    write_mode(m);
    repeat (n) send_points(rand_points());
  endtask

  initial begin
    pts_t dir_q[$];
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    pts_ch.valid = 1'b0;
    {pts_ch.ax, pts_ch.ay, pts_ch.bx, pts_ch.by,
     pts_ch.cx, pts_ch.cy, pts_ch.dx, pts_ch.dy} = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    dir_q = '{
      '{0, 0, 10, 10, 0, 10, 10, 0},
      '{0, 0, 0, 0, 1, 1, 2, 2},
      '{0, 0, 5, 5, 3, 3, 3, 3},
      '{0, 0, 10, 10, 0, 0, 10, 0},
      '{0, 0, 10, 0, 1, 1, 2, 2},
      '{0, 0, 10, 0, 1, -1, 2, -2},
      '{0, 0, 10, 0, 5, 0, 5, 5},
      '{0, 0, 10, 0, 20, -1, 20, 1},
      '{0, 0, 10, 0, 10, -1, 10, 1},
      '{0, 0, 10, 0, 0, 1, 0, 4},
      '{0, 0, 10, 0, 0, 1, 10, 1},
      '{0, 0, 3, 1, 1, 2, 2, -1},
      '{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768},
      '{32767, 32767, 32766, 32767, -32768, -32768, -32768, -32767},
      '{-32768, 0, -32767, 1, 32767, -1, 32767, 0},
      '{0, 0, 1, 0, 0, 1, 1, 2}
    };
    foreach (dir_q[i]) send_points(dir_q[i]);
    drain();
    write_mode(1'b1);
    foreach (dir_q[i]) send_points(dir_q[i]);

    run_phase(150, 0, 0, 1'b0);
    run_phase(150, 49, 0, 1'b1);
    run_phase(150, 0, 49, 1'b0);
    drain();
    run_phase(150, 10, 10, 1'b1);
    run_phase(150, 10, 10, 1'b0);
    run_phase(150, 0, 0, 1'b1);
    drain();
    recv_stall_pct = 0;

    $display("checked %0d results: found %0d, zero length %0d, shared %0d,",
             sb.n_checked, sb.n_status[0], sb.n_status[1], sb.n_status[2]);
    $display("  no crossing %0d, outside %0d, parallel %0d, both modes",
             sb.n_status[3], sb.n_status[4], sb.n_status[5]);
    if (sb.n_errors == 0 && sb.pending_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

@@ segment_intersection_point_core.f @@
src/sip_pkg.sv
src/sip_if.sv
src/sip_front.sv
src/sip_lane.sv
src/segment_intersection_point_core.sv
bench/sip_scoreboard.sv
bench/segment_intersection_point_core_test.sv
